### rtl/core/tcpq_pkg.sv
// ============================================================================
// tcpq_pkg
// Shared types, codes and helpers of the two-class priority queue.
// ============================================================================
`default_nettype none

package tcpq_pkg;

    // Field widths fixed by the interface
    localparam int KEY_W    = 64;
    localparam int FEE_W    = 16;
    localparam int INCOME_W = 32;

    // Configuration register indexes
    localparam logic REG_REGULAR_FEE = 1'b0;
    localparam logic REG_VIP_FEE     = 1'b1;

    // Fee reset values
    localparam logic [FEE_W-1:0] REGULAR_FEE_RST = 16'd10000;
    localparam logic [FEE_W-1:0] VIP_FEE_RST     = 16'd15000;

    typedef enum logic [1:0] {
        CMD_ADD    = 2'd0,
        CMD_SERVE  = 2'd1,
        CMD_CANCEL = 2'd2,
        CMD_FLUSH  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        STAT_DONE    = 2'd0,
        STAT_FULL    = 2'd1,
        STAT_EMPTY   = 2'd2,
        STAT_MISSING = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_SCAN,
        ST_REMOVE
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic    load;       // capture the input word, clear scan index
        logic    add;        // append at tail
        logic    flush;      // drop all entries
        logic    scan_next;  // advance scan index
        logic    sel_head;   // point scan index back at the head
        logic    remove;     // remove entry at scan index
        logic    charge;     // add entry fee to income
        logic    finish;     // present result word
        status_t status;
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic empty;
        logic full;
        logic last;     // scan index sits on the tail entry
        logic vip_hit;  // entry at scan index is vip
        logic key_hit;  // entry at scan index matches the key
    } dp_stat_t;

    // Upper-case every ASCII lower-case letter, byte by byte
    function automatic logic [KEY_W-1:0] fold_case(input logic [KEY_W-1:0] k);
        logic [KEY_W-1:0] r;
        logic [7:0]       b;
        r = k;
        for (int i = 0; i < KEY_W / 8; i++) begin
            b = k[8*i +: 8];
            if (b >= 8'h61 && b <= 8'h7A) begin
                r[8*i +: 8] = b - 8'h20;
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### rtl/core/tcpq_ctrl.sv
// ============================================================================
// tcpq_ctrl
// Command sequencer: dispatches each command and walks the entry scan.
// ============================================================================
`default_nettype none

module tcpq_ctrl
    import tcpq_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    input  wire logic [1:0] command,
    output logic            busy,
    input  dp_stat_t        dp_stat,
    output ctrl_cmd_t       ctrl_cmd
);

    state_t state_reg;
    state_t state_next;
    cmd_t   cmd_reg;
    cmd_t   cmd_next;
    logic   is_serve;
    logic   hit;

    // State and command registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cmd_reg   <= CMD_ADD;
        end
        else
        begin
            state_reg <= state_next;
            cmd_reg   <= cmd_next;
        end
    end

    assign is_serve = (cmd_reg == CMD_SERVE);
    assign hit      = is_serve ? dp_stat.vip_hit : dp_stat.key_hit;
    assign busy     = (state_reg != ST_IDLE);

    // Next state and datapath commands
    always_comb
    begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        ctrl_cmd   = '0;
        ctrl_cmd.status = STAT_DONE;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    ctrl_cmd.load = 1'b1;
                    cmd_next      = cmd_t'(command);
                    state_next    = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                unique case (cmd_reg)
                    CMD_ADD:
                    begin
                        ctrl_cmd.finish = 1'b1;
                        if (dp_stat.full)
                        begin
                            ctrl_cmd.status = STAT_FULL;
                        end
                        else
                        begin
                            ctrl_cmd.add = 1'b1;
                        end
                        state_next = ST_IDLE;
                    end
                    CMD_FLUSH:
                    begin
                        ctrl_cmd.flush  = 1'b1;
                        ctrl_cmd.finish = 1'b1;
                        state_next      = ST_IDLE;
                    end
                    CMD_SERVE, CMD_CANCEL:
                    begin
                        if (dp_stat.empty)
                        begin
                            ctrl_cmd.finish = 1'b1;
                            ctrl_cmd.status = STAT_EMPTY;
                            state_next      = ST_IDLE;
                        end
                        else
                        begin
                            state_next = ST_SCAN;
                        end
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_SCAN:
            begin
                priority if (hit)
                begin
                    state_next = ST_REMOVE;
                end
                else if (dp_stat.last)
                begin
                    // no vip present: serve the head instead
                    if (is_serve)
                    begin
                        ctrl_cmd.sel_head = 1'b1;
                        state_next        = ST_REMOVE;
                    end
                    else
                    begin
                        ctrl_cmd.finish = 1'b1;
                        ctrl_cmd.status = STAT_MISSING;
                        state_next      = ST_IDLE;
                    end
                end
                else
                begin
                    ctrl_cmd.scan_next = 1'b1;
                end
            end
            ST_REMOVE:
            begin
                ctrl_cmd.remove = 1'b1;
                ctrl_cmd.charge = is_serve;
                ctrl_cmd.finish = 1'b1;
                state_next      = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### rtl/core/tcpq_dp.sv
// ============================================================================
// tcpq_dp
// Entry store, scan index, fee registers, income and result registers.
// ============================================================================
`default_nettype none

module tcpq_dp
    import tcpq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 5,
    parameter int CNT_W       = $clog2(QUEUE_DEPTH + 1)
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                is_vip,
    input  wire logic [KEY_W-1:0]    plate_key,
    input  wire logic                cfg_wr,
    input  wire logic                cfg_index,
    input  wire logic [FEE_W-1:0]    cfg_data,
    input  ctrl_cmd_t                ctrl_cmd,
    output dp_stat_t                 dp_stat,
    output logic                     done,
    output logic [1:0]               status,
    output logic                     served_vip,
    output logic [KEY_W-1:0]         served_key,
    output logic [FEE_W-1:0]         fee,
    output logic [INCOME_W-1:0]      total_income,
    output logic [CNT_W-1:0]         occupancy
);

    localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    // Entry store, compacted toward index 0
    logic             class_reg [QUEUE_DEPTH];
    logic [KEY_W-1:0] key_reg   [QUEUE_DEPTH];
    logic             class_src [QUEUE_DEPTH];
    logic [KEY_W-1:0] key_src   [QUEUE_DEPTH];

    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic [IDX_W-1:0]    idx_reg;
    logic [IDX_W-1:0]    idx_next;
    logic [INCOME_W-1:0] income_reg;
    logic [INCOME_W-1:0] income_next;
    logic [INCOME_W:0]   income_sum;
    logic [FEE_W-1:0]    regular_fee_reg;
    logic [FEE_W-1:0]    vip_fee_reg;
    logic                in_vip_reg;
    logic [KEY_W-1:0]    in_key_reg;

    logic                done_reg;
    status_t             status_reg;
    logic                served_vip_reg;
    logic [KEY_W-1:0]    served_key_reg;
    logic [FEE_W-1:0]    fee_reg;

    logic                rd_class;
    logic [KEY_W-1:0]    rd_key;
    logic [FEE_W-1:0]    entry_fee;

    // Entry at the scan index
    assign rd_class  = class_reg[idx_reg];
    assign rd_key    = key_reg[idx_reg];
    assign entry_fee = rd_class ? vip_fee_reg : regular_fee_reg;

    // Status toward the controller
    assign dp_stat.empty   = (count_reg == '0);
    assign dp_stat.full    = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign dp_stat.last    = ((CNT_W'(idx_reg) + CNT_W'(1)) == count_reg);
    assign dp_stat.vip_hit = rd_class;
    assign dp_stat.key_hit = (fold_case(rd_key) == fold_case(in_key_reg));

    // Entry store: write at tail on add, shift down above the removed slot
    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_entry
        if (i < QUEUE_DEPTH - 1)
        begin : g_src
            assign class_src[i] = class_reg[i+1];
            assign key_src[i]   = key_reg[i+1];
        end
        else
        begin : g_tail
            assign class_src[i] = class_reg[i];
            assign key_src[i]   = key_reg[i];
        end

        always_ff @(posedge clk)
        begin
            if (ctrl_cmd.add && (count_reg == CNT_W'(i)))
            begin
                class_reg[i] <= in_vip_reg;
                key_reg[i]   <= in_key_reg;
            end
            else if (ctrl_cmd.remove && (idx_reg <= IDX_W'(i)))
            begin
                class_reg[i] <= class_src[i];
                key_reg[i]   <= key_src[i];
            end
        end
    end

    // Count, scan index and saturating income
    always_comb
    begin
        count_next = count_reg;
        if (ctrl_cmd.flush)
        begin
            count_next = '0;
        end
        else if (ctrl_cmd.add)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (ctrl_cmd.remove)
        begin
            count_next = count_reg - CNT_W'(1);
        end

        idx_next = idx_reg;
        if (ctrl_cmd.load || ctrl_cmd.sel_head)
        begin
            idx_next = '0;
        end
        else if (ctrl_cmd.scan_next)
        begin
            idx_next = idx_reg + IDX_W'(1);
        end

        income_sum  = {1'b0, income_reg} + (INCOME_W + 1)'(entry_fee);
        income_next = income_reg;
        if (ctrl_cmd.charge)
        begin
            income_next = income_sum[INCOME_W] ? {INCOME_W{1'b1}} : income_sum[INCOME_W-1:0];
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg       <= '0;
            idx_reg         <= '0;
            income_reg      <= '0;
            regular_fee_reg <= REGULAR_FEE_RST;
            vip_fee_reg     <= VIP_FEE_RST;
            done_reg        <= 1'b0;
        end
        else
        begin
            count_reg  <= count_next;
            idx_reg    <= idx_next;
            income_reg <= income_next;
            done_reg   <= ctrl_cmd.finish;
            if (cfg_wr)
            begin
                unique case (cfg_index)
                    REG_REGULAR_FEE: regular_fee_reg <= cfg_data;
                    REG_VIP_FEE:     vip_fee_reg     <= cfg_data;
                    default:         regular_fee_reg <= regular_fee_reg;
                endcase
            end
        end
    end

    // Input word capture and result word
    always_ff @(posedge clk)
    begin
        if (ctrl_cmd.load)
        begin
            in_vip_reg <= is_vip;
            in_key_reg <= plate_key;
        end
        if (ctrl_cmd.finish)
        begin
            status_reg <= ctrl_cmd.status;
            if (ctrl_cmd.remove)
            begin
                served_vip_reg <= rd_class;
                served_key_reg <= rd_key;
                fee_reg        <= ctrl_cmd.charge ? entry_fee : '0;
            end
            else
            begin
                served_vip_reg <= 1'b0;
                served_key_reg <= '0;
                fee_reg        <= '0;
            end
        end
    end

    assign done         = done_reg;
    assign status       = status_reg;
    assign served_vip   = served_vip_reg;
    assign served_key   = served_key_reg;
    assign fee          = fee_reg;
    assign total_income = income_reg;
    assign occupancy    = count_reg;

endmodule

`default_nettype wire

### rtl/core/two_class_priority_queue.sv
// ============================================================================
// two_class_priority_queue
// Ordered queue of regular and vip entries with priority serve and keyed cancel.
// ============================================================================
// Usage:
//   Command channel: a word (command, is_vip, plate_key) is taken at a rising
//   edge with start high and busy low. Commands: add at tail, serve oldest
//   vip (else head) and charge its fee, cancel first key match (letters
//   compared without case), flush.
//   Result channel: done is high for one cycle with status, served_vip,
//   served_key, fee, total_income and occupancy. The receiver cannot stall;
//   the result is held in registers so a new command may start while it shows.
//   Config channel: cfg_valid/cfg_ready (always ready), cfg_index selects
//   regular_fee (0) or vip_fee (1), cfg_data is the fee. Write only when idle.
// Sequence (accept to done): add, flush, and serve/cancel on an empty queue
//   finish from the decide state; serve and a successful cancel go on through
//   the scan to the remove state, and a cancel with no match ends in the scan.
//   The scan walks one entry a cycle, at most QUEUE_DEPTH entries, through a
//   single read port of the entry store.
// Reset: queue empty, income zero, fees back to 10000 and 15000.
// ============================================================================
`default_nettype none

module two_class_priority_queue
    import tcpq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 5
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire logic [1:0]          command,
    input  wire logic                is_vip,
    input  wire logic [KEY_W-1:0]    plate_key,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic                cfg_index,
    input  wire logic [FEE_W-1:0]    cfg_data,
    output logic                     done,
    output logic [1:0]               status,
    output logic                     served_vip,
    output logic [KEY_W-1:0]         served_key,
    output logic [FEE_W-1:0]         fee,
    output logic [INCOME_W-1:0]      total_income,
    output logic [$clog2(QUEUE_DEPTH + 1)-1:0] occupancy
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    ctrl_cmd_t ctrl_cmd;
    dp_stat_t  dp_stat;

    // Fee registers take a write in any cycle
    assign cfg_ready = 1'b1;

    tcpq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .command  (command),
        .busy     (busy),
        .dp_stat  (dp_stat),
        .ctrl_cmd (ctrl_cmd)
    );

    tcpq_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .CNT_W       (CNT_W)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .is_vip       (is_vip),
        .plate_key    (plate_key),
        .cfg_wr       (cfg_valid && cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .ctrl_cmd     (ctrl_cmd),
        .dp_stat      (dp_stat),
        .done         (done),
        .status       (status),
        .served_vip   (served_vip),
        .served_key   (served_key),
        .fee          (fee),
        .total_income (total_income),
        .occupancy    (occupancy)
    );

endmodule

`default_nettype wire

### rtl/core/tcpq_checker.sv
// ============================================================================
// tcpq_checker
// Port-level checks of the command/result sequencing of the queue.
// ============================================================================
`default_nettype none

module tcpq_checker
    import tcpq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 5,
    parameter int CNT_W       = $clog2(QUEUE_DEPTH + 1)
)
(
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                start,
    input wire logic                busy,
    input wire logic                done,
    input wire logic [1:0]          status,
    input wire logic [KEY_W-1:0]    served_key,
    input wire logic [FEE_W-1:0]    fee,
    input wire logic [CNT_W-1:0]    occupancy
);

    // An accepted word raises busy in the following cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted word did not raise busy");

    // A result only shows once the command has finished
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while still busy");

    // Every finished command yields a result word
    a_fall_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("command finished without a result");

    // Refused or failed commands remove nothing and charge nothing
    a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status != STAT_DONE)) |-> (fee == '0 && served_key == '0))
        else $error("failed command reported a removed entry");

    // Queue never holds more than its depth
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occupancy <= CNT_W'(QUEUE_DEPTH))
        else $error("occupancy beyond queue depth");

endmodule

bind two_class_priority_queue tcpq_checker #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .CNT_W       (CNT_W)
) u_tcpq_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .done       (done),
    .status     (status),
    .served_key (served_key),
    .fee        (fee),
    .occupancy  (occupancy)
);

`default_nettype wire
